/* sv/saes_pkg.sv */
// ----------------------------------------------------------------------------
// saes_pkg: shared definitions for the simplified AES cipher
// S-boxes, GF(2^4) arithmetic, round transforms, command codes and the round key type.
// ----------------------------------------------------------------------------
package saes_pkg;

   // command codes
   localparam logic CMD_ENCRYPT = 1'b0;
   localparam logic CMD_DECRYPT = 1'b1;

   // field polynomial x^4 + x + 1 and key schedule round constants
   localparam logic [4:0] GF_MODULUS = 5'b10011;
   localparam logic [3:0] GF_REDUCE  = GF_MODULUS[3:0];
   localparam logic [7:0] RCON_ONE   = 8'b1000_0000;
   localparam logic [7:0] RCON_TWO   = 8'b0011_0000;

   // MixColumns matrix entries: diagonal and off-diagonal
   localparam logic [3:0] MIX_FWD_DIAG = 4'h1;
   localparam logic [3:0] MIX_FWD_OFF  = 4'h4;
   localparam logic [3:0] MIX_INV_DIAG = 4'h9;
   localparam logic [3:0] MIX_INV_OFF  = 4'h2;

   localparam logic [3:0] FWD_SBOX [16] = '{
      4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
      4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7};

   localparam logic [3:0] INV_SBOX [16] = '{
      4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
      4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE};

   typedef struct packed {
      logic [15:0] k0;
      logic [15:0] k1;
      logic [15:0] k2;
   } round_keys_type;

   // GF(2^4) multiply, shift-and-add over four bits
   function automatic logic [3:0] gf_mul(input logic [3:0] x, input logic [3:0] y);
      logic [3:0] acc;
      logic [3:0] xs;
      acc = '0;
      xs  = x;
      for (int i = 0; i < 4; i++) begin
         if (y[i]) begin
            acc = acc ^ xs;
         end
         if (xs[3]) begin
            xs = {xs[2:0], 1'b0} ^ GF_REDUCE;
         end else begin
            xs = {xs[2:0], 1'b0};
         end
      end
      return acc;
   endfunction

   // key schedule word function: RotNib, SubNib, round constant
   function automatic logic [7:0] word_g(input logic [7:0] w, input logic [7:0] rcon);
      logic [7:0] rot;
      rot = {w[3:0], w[7:4]};
      return {FWD_SBOX[rot[7:4]], FWD_SBOX[rot[3:0]]} ^ rcon;
   endfunction

   function automatic logic [15:0] sub_fwd(input logic [15:0] v);
      return {FWD_SBOX[v[15:12]], FWD_SBOX[v[11:8]], FWD_SBOX[v[7:4]], FWD_SBOX[v[3:0]]};
   endfunction

   function automatic logic [15:0] sub_inv(input logic [15:0] v);
      return {INV_SBOX[v[15:12]], INV_SBOX[v[11:8]], INV_SBOX[v[7:4]], INV_SBOX[v[3:0]]};
   endfunction

   // swap of the two bottom-row nibbles
   function automatic logic [15:0] shift_rows(input logic [15:0] v);
      return {v[15:12], v[3:0], v[7:4], v[11:8]};
   endfunction

   function automatic logic [15:0] mix_columns(input logic [15:0] v,
                                               input logic [3:0] d,
                                               input logic [3:0] o);
      logic [3:0] a0;
      logic [3:0] a1;
      logic [3:0] b0;
      logic [3:0] b1;
      a0 = v[15:12];
      a1 = v[11:8];
      b0 = v[7:4];
      b1 = v[3:0];
      return {gf_mul(d, a0) ^ gf_mul(o, a1),
              gf_mul(o, a0) ^ gf_mul(d, a1),
              gf_mul(d, b0) ^ gf_mul(o, b1),
              gf_mul(o, b0) ^ gf_mul(d, b1)};
   endfunction

endpackage

/* sv/saes_key_expand.sv */
// ----------------------------------------------------------------------------
// saes_key_expand: round key schedule
// Expands the 16-bit cipher key into the three round keys K0, K1, K2.
// ----------------------------------------------------------------------------
module saes_key_expand (
   input  logic [15:0]              cipher_key,
   output saes_pkg::round_keys_type round_keys
);

   logic [7:0] w0, w1, w2, w3, w4, w5;

   // two word_g rounds over 8-bit words
   always_comb begin
      w0 = cipher_key[15:8];
      w1 = cipher_key[7:0];
      w2 = w0 ^ saes_pkg::word_g(w1, saes_pkg::RCON_ONE);
      w3 = w1 ^ w2;
      w4 = w2 ^ saes_pkg::word_g(w3, saes_pkg::RCON_TWO);
      w5 = w3 ^ w4;
      round_keys.k0 = cipher_key;
      round_keys.k1 = {w2, w3};
      round_keys.k2 = {w4, w5};
   end

endmodule

/* sv/saes_cipher_core.sv */
// ----------------------------------------------------------------------------
// saes_cipher_core: two-round cipher datapath
// Encrypts or decrypts one 16-bit block in a single combinational pass.
// ----------------------------------------------------------------------------
module saes_cipher_core (
   input  logic                     cmd,
   input  logic [15:0]              block_in,
   input  saes_pkg::round_keys_type round_keys,
   output logic [15:0]              block_out
);

   logic [15:0] enc_s;
   logic [15:0] dec_s;

   // forward rounds
   always_comb begin
      enc_s = block_in ^ round_keys.k0;
      enc_s = saes_pkg::shift_rows(saes_pkg::sub_fwd(enc_s));
      enc_s = saes_pkg::mix_columns(enc_s, saes_pkg::MIX_FWD_DIAG, saes_pkg::MIX_FWD_OFF);
      enc_s = enc_s ^ round_keys.k1;
      enc_s = saes_pkg::shift_rows(saes_pkg::sub_fwd(enc_s));
      enc_s = enc_s ^ round_keys.k2;
   end

   // inverse rounds, keys in reverse order
   always_comb begin
      dec_s = block_in ^ round_keys.k2;
      dec_s = saes_pkg::sub_inv(saes_pkg::shift_rows(dec_s));
      dec_s = dec_s ^ round_keys.k1;
      dec_s = saes_pkg::mix_columns(dec_s, saes_pkg::MIX_INV_DIAG, saes_pkg::MIX_INV_OFF);
      dec_s = saes_pkg::sub_inv(saes_pkg::shift_rows(dec_s));
      dec_s = dec_s ^ round_keys.k0;
   end

   assign block_out = (cmd == saes_pkg::CMD_DECRYPT) ? dec_s : enc_s;

endmodule

/* sv/simplified_aes_cipher.sv */
// ----------------------------------------------------------------------------
// simplified_aes_cipher: 16-bit two-round simplified AES
// Top level with key register, input register and result register.
// ----------------------------------------------------------------------------
// Each item carries a command (encrypt or decrypt) and one 16-bit block and
// returns one 16-bit block. The block takes one item per cycle while the
// receiver does not stall; a result passes from the input register through
// the single pass of key schedule and both rounds into the result register.
// The user writes the key through csr_write_enable/csr_write_data only while
// no item is in flight (the block itself does not enforce this); it applies
// to every item accepted afterwards.
module simplified_aes_cipher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_block_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_block_out,
   input  logic        csr_write_enable,
   input  logic [15:0] csr_write_data
);

   logic [15:0] key_ff;
   logic        in_valid_ff, in_valid_in;
   logic        in_cmd_ff;
   logic [15:0] in_block_ff;
   logic        out_valid_ff, out_valid_in;
   logic [15:0] out_block_ff;
   logic        out_load;
   logic [15:0] core_block;
   saes_pkg::round_keys_type round_keys;

   // key register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_enable) begin
         key_ff <= csr_write_data;
      end
   end

   saes_key_expand u_key_expand (
      .cipher_key (key_ff),
      .round_keys (round_keys)
   );

   // pipeline flow control
   assign out_load     = !out_valid_ff || rsp_ready;
   assign req_ready    = !in_valid_ff || out_load;
   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_load ? in_valid_ff : out_valid_ff;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cmd_ff   <= req_cmd;
         in_block_ff <= req_block_in;
      end
   end

   saes_cipher_core u_cipher_core (
      .cmd        (in_cmd_ff),
      .block_in   (in_block_ff),
      .round_keys (round_keys),
      .block_out  (core_block)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load && in_valid_ff) begin
         out_block_ff <= core_block;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = out_block_ff;

endmodule

/* verif/simplified_aes_cipher_tb.sv */
// ----------------------------------------------------------------------------
// simplified_aes_cipher_tb: self-checking bench for the 16-bit simplified AES
// Drives encrypt and decrypt items under several keys with bursty input and a
// stalling receiver. Expected blocks come from an independent cipher model
// held in a small scoreboard and are compared in order.
// ----------------------------------------------------------------------------
module simplified_aes_cipher_tb;

   // nibble substitution tables and key schedule constants
   localparam logic [3:0] ENC_NIBBLE [16] = '{
      4'h9, 4'h4, 4'hA, 4'hB, 4'hD, 4'h1, 4'h8, 4'h5,
      4'h6, 4'h2, 4'h0, 4'h3, 4'hC, 4'hE, 4'hF, 4'h7};
   localparam logic [3:0] DEC_NIBBLE [16] = '{
      4'hA, 4'h5, 4'h9, 4'hB, 4'h1, 4'h7, 4'h8, 4'hF,
      4'h6, 4'h0, 4'h2, 4'h3, 4'hC, 4'h4, 4'hD, 4'hE};
   localparam logic [3:0] FIELD_REDUCE = 4'h3;   // x^4 = x + 1
   localparam logic [7:0] KEY_RCON_ONE = 8'h80;
   localparam logic [7:0] KEY_RCON_TWO = 8'h30;
   localparam int         RANDOM_PHASES = 7;
   localparam int         PHASE_ITEMS   = 155;

   // ------------------------------------------------------------------------
   // cipher scoreboard: round keys, expected blocks in order, mismatch count
   // ------------------------------------------------------------------------
   class saes_scoreboard;
      logic [15:0] round_key [3];
      logic [15:0] expected_blocks [$];
      logic [15:0] last_block;
      logic        last_cmd;
      int unsigned mismatches;

      function new();
         mismatches = 0;
         last_block = '0;
         last_cmd   = saes_pkg::CMD_ENCRYPT;
         set_key(16'h0000);
      endfunction

      function automatic logic [3:0] field_mul(logic [3:0] a, logic [3:0] b);
         logic [3:0] acc;
         acc = '0;
         for (int i = 0; i < 4; i++) begin
            if (b[i]) begin
               acc ^= a;
            end
            a = a[3] ? ({a[2:0], 1'b0} ^ FIELD_REDUCE) : {a[2:0], 1'b0};
         end
         return acc;
      endfunction

      function automatic logic [15:0] nibble_sub(logic [15:0] v, bit inverse);
         logic [15:0] r;
         for (int i = 0; i < 4; i++) begin
            r[4*i +: 4] = inverse ? DEC_NIBBLE[v[4*i +: 4]] : ENC_NIBBLE[v[4*i +: 4]];
         end
         return r;
      endfunction

      // bottom row nibbles trade places
      function automatic logic [15:0] row_swap(logic [15:0] v);
         return {v[15:12], v[3:0], v[7:4], v[11:8]};
      endfunction

      function automatic logic [15:0] column_mix(logic [15:0] v, logic [3:0] d,
                                                 logic [3:0] o);
         return {field_mul(d, v[15:12]) ^ field_mul(o, v[11:8]),
                 field_mul(o, v[15:12]) ^ field_mul(d, v[11:8]),
                 field_mul(d, v[7:4])   ^ field_mul(o, v[3:0]),
                 field_mul(o, v[7:4])   ^ field_mul(d, v[3:0])};
      endfunction

      // RotNib, SubNib, then round constant
      function automatic logic [7:0] schedule_word(logic [7:0] w, logic [7:0] rc);
         return {ENC_NIBBLE[w[3:0]], ENC_NIBBLE[w[7:4]]} ^ rc;
      endfunction

      function void set_key(logic [15:0] key);
         logic [7:0] w2;
         logic [7:0] w3;
         logic [7:0] w4;
         w2 = key[15:8] ^ schedule_word(key[7:0], KEY_RCON_ONE);
         w3 = key[7:0] ^ w2;
         w4 = w2 ^ schedule_word(w3, KEY_RCON_TWO);
         round_key[0] = key;
         round_key[1] = {w2, w3};
         round_key[2] = {w4, w3 ^ w4};
      endfunction

      function automatic logic [15:0] cipher_block(logic cmd, logic [15:0] blk);
         logic [15:0] s;
         if (cmd == saes_pkg::CMD_ENCRYPT) begin
            s = blk ^ round_key[0];
            s = row_swap(nibble_sub(s, 1'b0));
            s = column_mix(s, 4'h1, 4'h4) ^ round_key[1];
            s = row_swap(nibble_sub(s, 1'b0)) ^ round_key[2];
         end else begin
            s = blk ^ round_key[2];
            s = nibble_sub(row_swap(s), 1'b1) ^ round_key[1];
            s = column_mix(s, 4'h9, 4'h2);
            s = nibble_sub(row_swap(s), 1'b1) ^ round_key[0];
         end
         return s;
      endfunction

      function void note_request(logic cmd, logic [15:0] blk);
         last_block = cipher_block(cmd, blk);
         last_cmd   = cmd;
         expected_blocks.push_back(last_block);
      endfunction

      function void check_response(logic [15:0] actual);
         logic [15:0] want;
         if (expected_blocks.size() == 0) begin
            $error("block_out: no item pending, actual %h", actual);
            mismatches++;
         end else begin
            want = expected_blocks.pop_front();
            if (actual !== want) begin
               $error("block_out: expected %h, actual %h", want, actual);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return expected_blocks.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [15:0] req_block_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_block_out;
   logic        csr_write_enable;
   logic [15:0] csr_write_data;

   saes_scoreboard sb;
   int unsigned    burst_left;
   logic [15:0]    ready_pattern;
   logic [3:0]     pattern_pos;

   simplified_aes_cipher DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_block_in     (req_block_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_block_out    (rsp_block_out),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // send one item; bursts of random length separated by random gaps
   task automatic send_item(input logic cmd, input logic [15:0] blk);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_block_in <= blk;
      do @(posedge clock); while (!(req_valid && req_ready));
      sb.note_request(cmd, blk);
      burst_left--;
   endtask

   // key write once the pipeline has drained
   task automatic load_key(input logic [15:0] key);
      req_valid  <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= key;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_key(key);
   endtask

   // receiver: check accepted items, stall on a random 16-bit pattern, stepped bit by bit
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_response(rsp_block_out);
      end
      rsp_ready <= ready_pattern[pattern_pos];
      pattern_pos++;
      if (pattern_pos == 4'd0) begin
         ready_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom()) | 16'h0001);
      end
   end

   // stimulus
   initial begin
      logic        cmd;
      logic [15:0] blk;
      int unsigned pick;
      sb               = new();
      burst_left       = 0;
      pattern_pos      = 4'd0;
      ready_pattern    = 16'hFFFF;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_cmd          <= saes_pkg::CMD_ENCRYPT;
      req_block_in     <= 16'h0000;
      rsp_ready        <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 16'h0000;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // key left at its reset value
      send_item(saes_pkg::CMD_ENCRYPT, 16'h0000);
      send_item(saes_pkg::CMD_DECRYPT, 16'h0000);
      send_item(saes_pkg::CMD_ENCRYPT, 16'hFFFF);
      send_item(saes_pkg::CMD_DECRYPT, 16'hFFFF);

      // textbook key and block, both directions, plus bit patterns
      load_key(16'h4AF5);
      send_item(saes_pkg::CMD_ENCRYPT, 16'hD728);
      send_item(saes_pkg::CMD_DECRYPT, 16'h24EC);
      send_item(saes_pkg::CMD_ENCRYPT, 16'hAAAA);
      send_item(saes_pkg::CMD_DECRYPT, 16'h5555);
      send_item(saes_pkg::CMD_ENCRYPT, 16'h8001);
      send_item(saes_pkg::CMD_DECRYPT, 16'h7FFE);
      send_item(saes_pkg::CMD_ENCRYPT, 16'h0F0F);
      send_item(saes_pkg::CMD_DECRYPT, 16'hF0F0);

      // all-ones key with extreme blocks
      load_key(16'hFFFF);
      send_item(saes_pkg::CMD_ENCRYPT, 16'h0000);
      send_item(saes_pkg::CMD_DECRYPT, 16'h0000);
      send_item(saes_pkg::CMD_ENCRYPT, 16'hFFFF);
      send_item(saes_pkg::CMD_DECRYPT, 16'hFFFF);

      // random phases; the first ones use extreme keys
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       load_key(16'h0000);
            1:       load_key(16'hFFFF);
            2:       load_key(16'h8000);
            3:       load_key(16'h0001);
            default: load_key(16'($urandom()));
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) begin
               // round trip: undo the previous item
               cmd = ~sb.last_cmd;
               blk = sb.last_block;
            end else if (pick == 3) begin
               cmd = 1'($urandom());
               blk = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            end else begin
               cmd = 1'($urandom());
               blk = 16'($urandom());
            end
            send_item(cmd, blk);
         end
      end

      // drain, then allow for stray results
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
